// ----- hw/rtl/srde_pkg.sv -----
// ----------------------------------------------------------------------------
// srde_pkg
// Shared types, constants and the alphabet lookup of the radix digit emitter.
// ----------------------------------------------------------------------------
package srde_pkg;

    localparam int MAX_SYMBOLS = 16;

    localparam logic [7:0] SIGN_MINUS = 8'h2D;
    localparam logic [7:0] SIGN_PLUS  = 8'h2B;

    // Configuration register indexes.
    localparam logic [1:0] REG_SYMBOL_COUNT = 2'd0;
    localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

    // Values after reset: radix ten with the symbols "0123456789".
    localparam logic [4:0]  RST_SYMBOL_COUNT = 5'd10;
    localparam logic [63:0] RST_SYMBOLS_LOW  = 64'h3736353433323130;
    localparam logic [63:0] RST_SYMBOLS_HIGH = 64'h0000000000003938;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ERR,
        ST_SIGN,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

    // Status word from the alphabet checker.
    typedef struct packed {
        logic done;
        logic ok;
    } chk_status_t;

    // Symbol for digit d: bytes 0 to 7 of the low word, then of the high word.
    function automatic logic [7:0] alpha_symbol(input logic [63:0] sym_low,
                                                input logic [63:0] sym_high,
                                                input logic [3:0]  d);
        logic [63:0] word;
        word = d[3] ? sym_high : sym_low;
        return word[{d[2:0], 3'b000} +: 8];
    endfunction

endpackage

// ----- hw/rtl/srde_divider.sv -----
// ----------------------------------------------------------------------------
// srde_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srde_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [4:0]  divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [4:0]  remainder
);
    import srde_pkg::*;

    logic [31:0] quot_reg;
    logic [4:0]  rem_reg;
    logic [4:0]  div_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [5:0]  trial;
    logic        fits;
    logic [5:0]  diff;
    logic [4:0]  rem_next;

    // For a nonzero divisor the remainder stays below the divisor, so five bits hold it.
    assign trial    = {rem_reg, quot_reg[31]};
    assign fits     = (trial >= {1'b0, div_reg});
    assign diff     = trial - {1'b0, div_reg};
    assign rem_next = fits ? diff[4:0] : trial[4:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[30:0], fits};
            rem_reg  <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

// ----- hw/rtl/srde_alpha_check.sv -----
// ----------------------------------------------------------------------------
// srde_alpha_check
// Checks the symbol count, then scans the alphabet one symbol per cycle for sign characters and repeats.
// ----------------------------------------------------------------------------
module srde_alpha_check
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [4:0]          count,
    input  logic [63:0]         sym_low,
    input  logic [63:0]         sym_high,
    output srde_pkg::chk_status_t status
);
    import srde_pkg::*;

    logic [3:0] idx_reg;
    logic       busy_reg;
    logic       done_reg;
    logic       bad_reg;

    logic       count_bad;
    logic [7:0] sym_i;
    logic       sym_bad;

    assign count_bad = (count < 5'd2) || (count > 5'(MAX_SYMBOLS));
    assign sym_i     = alpha_symbol(sym_low, sym_high, idx_reg);

    // Symbol idx_reg, if in use, against the sign characters and every later symbol that is in use.
    always_comb
    begin
        sym_bad = 1'b0;
        if ({1'b0, idx_reg} < count)
        begin
            if ((sym_i == SIGN_PLUS) || (sym_i == SIGN_MINUS))
                sym_bad = 1'b1;
            for (int j = 0; j < 16; j++)
            begin
                if ((4'(j) > idx_reg) && (5'(j) < count)
                    && (alpha_symbol(sym_low, sym_high, 4'(j)) == sym_i))
                    sym_bad = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bad_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                idx_reg  <= '0;
                busy_reg <= 1'b1;
                bad_reg  <= count_bad;
            end
            else if (busy_reg)
            begin
                bad_reg <= bad_reg | sym_bad;
                idx_reg <= idx_reg + 4'd1;
                if (idx_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.done = done_reg;
    assign status.ok   = !bad_reg;

endmodule

// ----- hw/rtl/signed_radix_digit_emitter_top.sv -----
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter_top
// Converts a signed 32-bit word into symbols of a configured radix.
// ----------------------------------------------------------------------------
// The input channel takes one word, value, when in_valid is high and in_stall
// is low. The output channel gives one symbol per word, most significant
// digit first, with a leading '-' for negative values; last marks the final
// word of a conversion. An invalid alphabet gives one word with bad_alphabet
// and last set and symbol zero.
// One input goes through the alphabet scan, the '-' word for a negative
// value, one division per digit on the single divider, and then one word
// per cycle for the digits while the receiver does not stall. in_stall stays
// high from acceptance until the final word is loaded into the output
// register; the next word can be accepted while that final word waits.
// While the receiver stalls a valid word, the output register keeps it and
// no new word is loaded. Reset clears the sequencer and the output valid and
// loads the registers with radix ten and the symbols "0123456789".
// Configuration writes via wr_en, wr_index, wr_data take effect at once and
// must only be made while the block is idle with no conversion in flight.
// ----------------------------------------------------------------------------
module signed_radix_digit_emitter_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [63:0] wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  symbol,
    output logic        last,
    output logic        bad_alphabet
);
    import srde_pkg::*;

    // Configuration registers.
    logic [4:0]  symbol_count_reg;
    logic [63:0] symbols_low_reg;
    logic [63:0] symbols_high_reg;

    state_t      state_reg;
    state_t      state_next;

    logic        neg_reg;
    logic [31:0] mag_reg;
    logic [4:0]  nd_reg;
    logic [4:0]  idx_reg;
    logic [3:0]  digit_mem [32];

    logic        out_valid_reg;
    logic [7:0]  symbol_reg;
    logic        last_reg;
    logic        bad_reg;

    chk_status_t chk;
    logic        div_done;
    logic [31:0] div_quot;
    logic [4:0]  div_rem;

    // Sequencer outputs.
    logic        accept;
    logic        chk_start;
    logic        div_start;
    logic        digit_wr;
    logic        div_finish;
    logic        out_load;
    logic [7:0]  out_sym;
    logic        out_last;
    logic        out_bad;

    logic        out_free;

    assign out_free   = !out_valid_reg || !out_stall;
    assign div_finish = (div_quot == 32'd0) || (nd_reg == 5'd31);

    srde_alpha_check u_check
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (chk_start),
        .count    (symbol_count_reg),
        .sym_low  (symbols_low_reg),
        .sym_high (symbols_high_reg),
        .status   (chk)
    );

    srde_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag_reg),
        .divisor   (symbol_count_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_CHECK;
            ST_CHECK:
                if (chk.done)
                begin
                    if (!chk.ok)
                        state_next = ST_ERR;
                    else if (neg_reg)
                        state_next = ST_SIGN;
                    else
                        state_next = ST_DIV_START;
                end
            ST_ERR:
                if (out_free)
                    state_next = ST_IDLE;
            ST_SIGN:
                if (out_free)
                    state_next = ST_DIV_START;
            ST_DIV_START:
                state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (div_done)
                    state_next = div_finish ? ST_EMIT : ST_DIV_START;
            ST_EMIT:
                if (out_free && (idx_reg == 5'd0))
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        accept    = 1'b0;
        chk_start = 1'b0;
        div_start = 1'b0;
        digit_wr  = 1'b0;
        out_load  = 1'b0;
        out_sym   = 8'd0;
        out_last  = 1'b0;
        out_bad   = 1'b0;
        in_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                accept    = in_valid;
                chk_start = in_valid;
            end
            ST_CHECK:
            begin
            end
            ST_ERR:
            begin
                out_load = out_free;
                out_last = 1'b1;
                out_bad  = 1'b1;
            end
            ST_SIGN:
            begin
                out_load = out_free;
                out_sym  = SIGN_MINUS;
            end
            ST_DIV_START:
                div_start = 1'b1;
            ST_DIV_WAIT:
                digit_wr = div_done;
            ST_EMIT:
            begin
                out_load = out_free;
                out_sym  = alpha_symbol(symbols_low_reg, symbols_high_reg,
                                        digit_mem[idx_reg]);
                out_last = (idx_reg == 5'd0);
            end
            default:
            begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            symbol_count_reg <= RST_SYMBOL_COUNT;
            symbols_low_reg  <= RST_SYMBOLS_LOW;
            symbols_high_reg <= RST_SYMBOLS_HIGH;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_SYMBOL_COUNT: symbol_count_reg <= wr_data[4:0];
                    REG_SYMBOLS_LOW:  symbols_low_reg  <= wr_data;
                    REG_SYMBOLS_HIGH: symbols_high_reg <= wr_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            neg_reg <= value[31];
            mag_reg <= value[31] ? (32'd0 - value) : value;
            nd_reg  <= '0;
        end
        if (digit_wr)
        begin
            digit_mem[nd_reg] <= div_rem[3:0];
            mag_reg           <= div_quot;
            if (div_finish)
                idx_reg <= nd_reg;
            else
                nd_reg <= nd_reg + 5'd1;
        end
        if (out_load)
        begin
            symbol_reg <= out_sym;
            last_reg   <= out_last;
            bad_reg    <= out_bad;
            if ((state_reg == ST_EMIT) && (idx_reg != 5'd0))
                idx_reg <= idx_reg - 5'd1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign symbol       = symbol_reg;
    assign last         = last_reg;
    assign bad_alphabet = bad_reg;

endmodule

// ----- hw/rtl/srde_checker.sv -----
// ----------------------------------------------------------------------------
// srde_checker
// Port-level assertions for the radix digit emitter.
// ----------------------------------------------------------------------------
module srde_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] symbol,
    input logic       last,
    input logic       bad_alphabet
);
    import srde_pkg::*;

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(symbol)
            && $stable(last) && $stable(bad_alphabet))
        else $error("output word changed while stalled");

    // The error word is the single and final word of its conversion.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_alphabet |-> last && (symbol == 8'd0))
        else $error("error word is not a lone zero word");

    // A sign is never the final word.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bad_alphabet && (symbol == SIGN_MINUS) |-> !last)
        else $error("minus sign emitted as final word");

    // The block is busy right after taking a word.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

endmodule

bind signed_radix_digit_emitter_top srde_checker u_srde_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .symbol       (symbol),
    .last         (last),
    .bad_alphabet (bad_alphabet)
);
